@@ rtl/core/dba_pkg.sv @@
// Shared types, status codes and register indexes for the datagram budget block.
`timescale 1ns / 1ps
`default_nettype none

package dba_pkg;

  // Default counter widths
  localparam int COUNT_BITS_DEF = 32;
  localparam int BYTE_BITS_DEF  = 48;

  // Field and register widths of the ports
  localparam int LEN_W      = 16;
  localparam int CNT_PORT_W = 32;
  localparam int BYT_PORT_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PAYLOAD  = 3'd1,
    ST_DATAGRAM = 3'd2,
    ST_RAW      = 3'd3,
    ST_CLIENT   = 3'd4,
    ST_SERVER   = 3'd5,
    ST_EMIT     = 3'd6
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DGRAMS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RAW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CLIENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SERVER  = 3'd4;

  // Item commands
  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_EMIT    = 1'b1;

  // One input beat
  typedef struct packed {
    logic             cmd;
    logic             toward_client;
    logic [LEN_W-1:0] payload_len;
  } item_t;

  // Budget limits as programmed
  typedef struct packed {
    logic [LEN_W-1:0]      max_payload;
    logic [CNT_PORT_W-1:0] max_datagrams;
    logic [BYT_PORT_W-1:0] max_raw_bytes;
    logic [CNT_PORT_W-1:0] max_client_packets;
    logic [CNT_PORT_W-1:0] max_server_packets;
  } limits_t;

endpackage

`default_nettype wire

@@ rtl/core/dba_ledger.sv @@
// Budget counters with the admission and emission checks for one item.
`timescale 1ns / 1ps
`default_nettype none

module dba_ledger #(
  parameter int COUNT_BITS = dba_pkg::COUNT_BITS_DEF,
  parameter int BYTE_BITS  = dba_pkg::BYTE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire dba_pkg::item_t        item,
  input  wire dba_pkg::limits_t      lim,
  output dba_pkg::status_t           status,
  output logic [COUNT_BITS-1:0]      seen_cnt_next,
  output logic [BYTE_BITS-1:0]       seen_bytes_next,
  output logic [COUNT_BITS-1:0]      client_cnt_next,
  output logic [COUNT_BITS-1:0]      server_cnt_next,
  output logic [COUNT_BITS-1:0]      sent_cnt_next,
  output logic [BYTE_BITS-1:0]       sent_bytes_next
);

  localparam int CMP_W = 65;

  logic [COUNT_BITS-1:0] observed_count;
  logic [BYTE_BITS-1:0]  observed_bytes;
  logic [COUNT_BITS-1:0] client_total;
  logic [COUNT_BITS-1:0] server_total;
  logic [COUNT_BITS-1:0] emitted_count;
  logic [BYTE_BITS-1:0]  emitted_total_bytes;

  logic [BYTE_BITS:0] raw_sum;
  logic [BYTE_BITS:0] emit_sum;
  logic payload_fail, dgram_fail, raw_fail, client_fail, server_fail, emit_fail;
  logic obs_ok, emit_ok;

  // Sums carry one extra bit so the top of the counter shows as a carry
  assign raw_sum  = (BYTE_BITS+1)'(observed_bytes) + (BYTE_BITS+1)'(item.payload_len);
  assign emit_sum = (BYTE_BITS+1)'(emitted_total_bytes) + (BYTE_BITS+1)'(item.payload_len);

  // Limits are capped at the counter top: a full counter fails its check too
  assign payload_fail = item.payload_len > lim.max_payload;
  assign dgram_fail   = (CMP_W'(observed_count) >= CMP_W'(lim.max_datagrams))
                        || (&observed_count);
  assign raw_fail     = (CMP_W'(raw_sum) > CMP_W'(lim.max_raw_bytes)) || raw_sum[BYTE_BITS];
  assign client_fail  = !item.toward_client
                        && ((CMP_W'(client_total) >= CMP_W'(lim.max_client_packets))
                            || (&client_total));
  assign server_fail  = item.toward_client
                        && ((CMP_W'(server_total) >= CMP_W'(lim.max_server_packets))
                            || (&server_total));
  assign emit_fail    = (&emitted_count) || emit_sum[BYTE_BITS];

  // Pick the first failing check
  always_comb begin
    if (item.cmd == dba_pkg::CMD_EMIT) begin
      status = emit_fail ? dba_pkg::ST_EMIT : dba_pkg::ST_OK;
    end else if (payload_fail) begin
      status = dba_pkg::ST_PAYLOAD;
    end else if (dgram_fail) begin
      status = dba_pkg::ST_DATAGRAM;
    end else if (raw_fail) begin
      status = dba_pkg::ST_RAW;
    end else if (client_fail) begin
      status = dba_pkg::ST_CLIENT;
    end else if (server_fail) begin
      status = dba_pkg::ST_SERVER;
    end else begin
      status = dba_pkg::ST_OK;
    end
  end

  assign obs_ok  = (item.cmd == dba_pkg::CMD_OBSERVE) && (status == dba_pkg::ST_OK);
  assign emit_ok = (item.cmd == dba_pkg::CMD_EMIT) && (status == dba_pkg::ST_OK);

  // Counter values after this item
  always_comb begin
    seen_cnt_next   = observed_count;
    seen_bytes_next = observed_bytes;
    client_cnt_next = client_total;
    server_cnt_next = server_total;
    sent_cnt_next   = emitted_count;
    sent_bytes_next = emitted_total_bytes;
    if (obs_ok) begin
      seen_cnt_next   = observed_count + COUNT_BITS'(1);
      seen_bytes_next = raw_sum[BYTE_BITS-1:0];
      if (item.toward_client) begin
        server_cnt_next = server_total + COUNT_BITS'(1);
      end else begin
        client_cnt_next = client_total + COUNT_BITS'(1);
      end
    end
    if (emit_ok) begin
      sent_cnt_next   = emitted_count + COUNT_BITS'(1);
      sent_bytes_next = emit_sum[BYTE_BITS-1:0];
    end
  end

  // Commit the counters when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      observed_count      <= '0;
      observed_bytes      <= '0;
      client_total        <= '0;
      server_total        <= '0;
      emitted_count       <= '0;
      emitted_total_bytes <= '0;
    end else if (step) begin
      observed_count      <= seen_cnt_next;
      observed_bytes      <= seen_bytes_next;
      client_total        <= client_cnt_next;
      server_total        <= server_cnt_next;
      emitted_count       <= sent_cnt_next;
      emitted_total_bytes <= sent_bytes_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/datagram_budget_admission.sv @@
// Top level of the datagram budget admission block.
`timescale 1ns / 1ps
`default_nettype none

// Checks each datagram beat against packet and byte budgets and keeps the
// observed, per-direction and emitted counters. The block takes one beat per
// clock cycle unless the result side stalls it; a beat passes the input
// register, then the result register. Counters commit as each beat moves
// on, so each beat sees every earlier beat's effect. Result back-pressure
// stalls intake only once both the input and result registers are full.
// The user must write limit registers through cfg_write/cfg_index/cfg_data
// only while no beat is in flight; the block itself does not enforce this.
// Indexes past the last register are ignored. All limits reset to all ones.
module datagram_budget_admission #(
  parameter int COUNT_BITS = dba_pkg::COUNT_BITS_DEF,
  parameter int BYTE_BITS  = dba_pkg::BYTE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             cmd,
  input  wire logic                             toward_client,
  input  wire logic [dba_pkg::LEN_W-1:0]        payload_len,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [2:0]                            status,
  output logic [dba_pkg::CNT_PORT_W-1:0]        seen_datagrams,
  output logic [dba_pkg::BYT_PORT_W-1:0]        seen_bytes,
  output logic [dba_pkg::CNT_PORT_W-1:0]        client_count,
  output logic [dba_pkg::CNT_PORT_W-1:0]        server_count,
  output logic [dba_pkg::CNT_PORT_W-1:0]        sent_datagrams,
  output logic [dba_pkg::BYT_PORT_W-1:0]        sent_bytes,
  // Configuration port
  input  wire logic                             cfg_write,
  input  wire logic [dba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dba_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int EXT_W = 64;

  dba_pkg::limits_t lim;
  dba_pkg::item_t   s1_item;
  logic             s1_valid;
  logic             advance;

  dba_pkg::status_t      led_status;
  logic [COUNT_BITS-1:0] seen_cnt_next, client_cnt_next, server_cnt_next, sent_cnt_next;
  logic [BYTE_BITS-1:0]  seen_bytes_next, sent_bytes_next;
  logic [EXT_W-1:0]      seen_cnt_ext, client_cnt_ext, server_cnt_ext, sent_cnt_ext;
  logic [EXT_W-1:0]      seen_bytes_ext, sent_bytes_ext;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim.max_payload        <= '1;
      lim.max_datagrams      <= '1;
      lim.max_raw_bytes      <= '1;
      lim.max_client_packets <= '1;
      lim.max_server_packets <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        dba_pkg::REG_MAX_PAYLOAD: lim.max_payload <= cfg_data[dba_pkg::LEN_W-1:0];
        dba_pkg::REG_MAX_DGRAMS:  lim.max_datagrams <= cfg_data[dba_pkg::CNT_PORT_W-1:0];
        dba_pkg::REG_MAX_RAW:     lim.max_raw_bytes <= cfg_data[dba_pkg::BYT_PORT_W-1:0];
        dba_pkg::REG_MAX_CLIENT:  lim.max_client_packets <= cfg_data[dba_pkg::CNT_PORT_W-1:0];
        dba_pkg::REG_MAX_SERVER:  lim.max_server_packets <= cfg_data[dba_pkg::CNT_PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Move the held beat forward when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.cmd           <= cmd;
      s1_item.toward_client <= toward_client;
      s1_item.payload_len   <= payload_len;
    end
  end

  dba_ledger #(
    .COUNT_BITS (COUNT_BITS),
    .BYTE_BITS  (BYTE_BITS)
  ) u_ledger (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .item            (s1_item),
    .lim             (lim),
    .status          (led_status),
    .seen_cnt_next   (seen_cnt_next),
    .seen_bytes_next (seen_bytes_next),
    .client_cnt_next (client_cnt_next),
    .server_cnt_next (server_cnt_next),
    .sent_cnt_next   (sent_cnt_next),
    .sent_bytes_next (sent_bytes_next)
  );

  // Fit the counters to the port widths
  assign seen_cnt_ext   = EXT_W'(seen_cnt_next);
  assign client_cnt_ext = EXT_W'(client_cnt_next);
  assign server_cnt_ext = EXT_W'(server_cnt_next);
  assign sent_cnt_ext   = EXT_W'(sent_cnt_next);
  assign seen_bytes_ext = EXT_W'(seen_bytes_next);
  assign sent_bytes_ext = EXT_W'(sent_bytes_next);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status         <= led_status;
      seen_datagrams <= seen_cnt_ext[dba_pkg::CNT_PORT_W-1:0];
      seen_bytes     <= seen_bytes_ext[dba_pkg::BYT_PORT_W-1:0];
      client_count   <= client_cnt_ext[dba_pkg::CNT_PORT_W-1:0];
      server_count   <= server_cnt_ext[dba_pkg::CNT_PORT_W-1:0];
      sent_datagrams <= sent_cnt_ext[dba_pkg::CNT_PORT_W-1:0];
      sent_bytes     <= sent_bytes_ext[dba_pkg::BYT_PORT_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dba_checker.sv @@
// Port-level checks for the datagram budget block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module dba_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [2:0]                     status,
  input wire logic [dba_pkg::CNT_PORT_W-1:0] seen_datagrams,
  input wire logic [dba_pkg::BYT_PORT_W-1:0] seen_bytes,
  input wire logic [dba_pkg::CNT_PORT_W-1:0] client_count,
  input wire logic [dba_pkg::CNT_PORT_W-1:0] server_count,
  input wire logic [dba_pkg::CNT_PORT_W-1:0] sent_datagrams,
  input wire logic [dba_pkg::BYT_PORT_W-1:0] sent_bytes
);

  // No result is shown right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Every accepted observation bumps exactly one direction counter
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (seen_datagrams == (client_count + server_count)))
    else $error("direction counters do not add up to observed count");

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(seen_datagrams) && $stable(seen_bytes)
      && $stable(sent_datagrams) && $stable(sent_bytes))
    else $error("stalled result changed");

  // With the result side free, intake is never blocked
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result side is empty");

endmodule

bind datagram_budget_admission dba_checker u_dba_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for datagram_budget_admission: directed limit table, then random phases.
`timescale 1ns / 1ps

module tb;

  localparam int RUN_LIMIT    = 1000000;
  localparam int RANDOM_BEATS = 1800;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [dba_pkg::CNT_PORT_W-1:0] CNT_TOP = '1;
  localparam logic [dba_pkg::BYT_PORT_W-1:0] BYT_TOP = '1;
  localparam logic [dba_pkg::CFG_DATA_W-1:0] ALL_ONES = '1;

  // Indexes past the last limit register
  localparam logic [dba_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = dba_pkg::REG_MAX_SERVER + 1'b1;
  localparam logic [dba_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  typedef struct packed {
    dba_pkg::status_t               st;
    logic [dba_pkg::CNT_PORT_W-1:0] seen;
    logic [dba_pkg::BYT_PORT_W-1:0] bytes;
    logic [dba_pkg::CNT_PORT_W-1:0] client;
    logic [dba_pkg::CNT_PORT_W-1:0] server;
    logic [dba_pkg::CNT_PORT_W-1:0] sent;
    logic [dba_pkg::BYT_PORT_W-1:0] sbytes;
  } budget_res_t;

  typedef struct {
    bit                             is_cfg;
    logic [dba_pkg::CFG_IDX_W-1:0]  idx;
    logic [dba_pkg::CFG_DATA_W-1:0] data;
    dba_pkg::item_t                 beat;
    bit                             typed;
    budget_res_t                    res;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           cmd = dba_pkg::CMD_OBSERVE;
  logic                           toward_client = 1'b0;
  logic [dba_pkg::LEN_W-1:0]      payload_len = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [2:0]                     status;
  logic [dba_pkg::CNT_PORT_W-1:0] seen_datagrams;
  logic [dba_pkg::BYT_PORT_W-1:0] seen_bytes;
  logic [dba_pkg::CNT_PORT_W-1:0] client_count;
  logic [dba_pkg::CNT_PORT_W-1:0] server_count;
  logic [dba_pkg::CNT_PORT_W-1:0] sent_datagrams;
  logic [dba_pkg::BYT_PORT_W-1:0] sent_bytes;
  logic                           cfg_write = 1'b0;
  logic [dba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Budget model: limits and counters
  logic [dba_pkg::LEN_W-1:0]      lim_payload;
  logic [dba_pkg::CNT_PORT_W-1:0] lim_dgrams;
  logic [dba_pkg::BYT_PORT_W-1:0] lim_raw;
  logic [dba_pkg::CNT_PORT_W-1:0] lim_client;
  logic [dba_pkg::CNT_PORT_W-1:0] lim_server;
  logic [dba_pkg::CNT_PORT_W-1:0] seen_cnt;
  logic [dba_pkg::BYT_PORT_W-1:0] seen_byt;
  logic [dba_pkg::CNT_PORT_W-1:0] client_cnt;
  logic [dba_pkg::CNT_PORT_W-1:0] server_cnt;
  logic [dba_pkg::CNT_PORT_W-1:0] sent_cnt;
  logic [dba_pkg::BYT_PORT_W-1:0] sent_byt;

  budget_res_t pending_results[$];
  budget_res_t want_r;
  budget_res_t got_r;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          no_gaps = 1'b0;
  bit          held_off = 1'b0;

  datagram_budget_admission i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .toward_client (toward_client),
    .payload_len   (payload_len),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .seen_datagrams(seen_datagrams),
    .seen_bytes    (seen_bytes),
    .client_count  (client_count),
    .server_count  (server_count),
    .sent_datagrams(sent_datagrams),
    .sent_bytes    (sent_bytes),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one beat to the budget counters and return the result it produces
  function automatic budget_res_t admit_beat(dba_pkg::item_t b);
    budget_res_t                    r;
    dba_pkg::status_t               st;
    logic [dba_pkg::BYT_PORT_W-1:0] len;
    st  = dba_pkg::ST_OK;
    len = dba_pkg::BYT_PORT_W'(b.payload_len);
    if (b.cmd == dba_pkg::CMD_EMIT) begin
      // Emission ignores direction; refuse if either counter would pass its top
      if (sent_cnt == CNT_TOP || len > BYT_TOP - sent_byt) begin
        st = dba_pkg::ST_EMIT;
      end else begin
        sent_cnt = sent_cnt + 1'b1;
        sent_byt = sent_byt + len;
      end
    end else begin
      if (b.payload_len > lim_payload) begin
        st = dba_pkg::ST_PAYLOAD;
      end else if (seen_cnt >= lim_dgrams) begin
        st = dba_pkg::ST_DATAGRAM;
      end else if (seen_byt > lim_raw || len > lim_raw - seen_byt) begin
        st = dba_pkg::ST_RAW;
      end else if (!b.toward_client && client_cnt >= lim_client) begin
        st = dba_pkg::ST_CLIENT;
      end else if (b.toward_client && server_cnt >= lim_server) begin
        st = dba_pkg::ST_SERVER;
      end else begin
        seen_cnt = seen_cnt + 1'b1;
        seen_byt = seen_byt + len;
        if (b.toward_client) server_cnt = server_cnt + 1'b1;
        else client_cnt = client_cnt + 1'b1;
      end
    end
    r.st     = st;
    r.seen   = seen_cnt;
    r.bytes  = seen_byt;
    r.client = client_cnt;
    r.server = server_cnt;
    r.sent   = sent_cnt;
    r.sbytes = sent_byt;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [dba_pkg::CFG_IDX_W-1:0] idx,
                                        logic [dba_pkg::CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic stim_row_t beat_row(logic c, logic d, logic [dba_pkg::LEN_W-1:0] len);
    stim_row_t r;
    r = '{default: '0};
    r.beat.cmd           = c;
    r.beat.toward_client = d;
    r.beat.payload_len   = len;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic c, logic d, logic [dba_pkg::LEN_W-1:0] len,
                                          dba_pkg::status_t st,
                                          logic [47:0] sn, logic [47:0] sb,
                                          logic [47:0] cl, logic [47:0] sv,
                                          logic [47:0] nt, logic [47:0] nb);
    stim_row_t r;
    r = beat_row(c, d, len);
    r.typed      = 1'b1;
    r.res.st     = st;
    r.res.seen   = sn[dba_pkg::CNT_PORT_W-1:0];
    r.res.bytes  = sb;
    r.res.client = cl[dba_pkg::CNT_PORT_W-1:0];
    r.res.server = sv[dba_pkg::CNT_PORT_W-1:0];
    r.res.sent   = nt[dba_pkg::CNT_PORT_W-1:0];
    r.res.sbytes = nb;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int sel;
    if (no_gaps) return 0;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 0;
    if (sel < 17) return $urandom_range(1, 3);
    if (sel < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [dba_pkg::LEN_W-1:0] pick_payload_limit();
    case ($urandom_range(0, 7))
      0, 1:    return '1;
      2:       return '0;
      3:       return 1;
      default: return dba_pkg::LEN_W'($urandom);
    endcase
  endfunction

  // Count limits sit mostly a little above the present count so they get hit
  function automatic logic [dba_pkg::CNT_PORT_W-1:0] pick_count_limit(
      logic [dba_pkg::CNT_PORT_W-1:0] cur);
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return 1;
      3:       return $urandom;
      default: return cur + $urandom_range(0, 60);
    endcase
  endfunction

  function automatic logic [dba_pkg::BYT_PORT_W-1:0] pick_raw_limit();
    case ($urandom_range(0, 6))
      0:       return '1;
      1:       return '0;
      2:       return {16'($urandom), 32'($urandom)};
      default: return seen_byt + $urandom_range(0, 3000000);
    endcase
  endfunction

  function automatic dba_pkg::item_t random_beat();
    dba_pkg::item_t b;
    b.cmd           = ($urandom_range(0, 9) < 3) ? dba_pkg::CMD_EMIT : dba_pkg::CMD_OBSERVE;
    b.toward_client = $urandom_range(0, 1);
    case ($urandom_range(0, 7))
      0:       b.payload_len = '0;
      1:       b.payload_len = '1;
      2, 3:    b.payload_len = dba_pkg::LEN_W'(int'(lim_payload) + $urandom_range(0, 4) - 2);
      default: b.payload_len = dba_pkg::LEN_W'($urandom);
    endcase
    return b;
  endfunction

  // Drive one limit write; cfg_write is dropped by the next beat
  task automatic write_limit(logic [dba_pkg::CFG_IDX_W-1:0] idx,
                             logic [dba_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      dba_pkg::REG_MAX_PAYLOAD: lim_payload = data[dba_pkg::LEN_W-1:0];
      dba_pkg::REG_MAX_DGRAMS:  lim_dgrams  = data[dba_pkg::CNT_PORT_W-1:0];
      dba_pkg::REG_MAX_RAW:     lim_raw     = data[dba_pkg::BYT_PORT_W-1:0];
      dba_pkg::REG_MAX_CLIENT:  lim_client  = data[dba_pkg::CNT_PORT_W-1:0];
      dba_pkg::REG_MAX_SERVER:  lim_server  = data[dba_pkg::CNT_PORT_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one beat, hold it until accepted, then queue its expected result
  task automatic offer_beat(dba_pkg::item_t b, bit typed, budget_res_t res);
    int          gap;
    budget_res_t pred;
    gap = pick_gap();
    cfg_write <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= b.cmd;
    toward_client <= b.toward_client;
    payload_len   <= b.payload_len;
    do @(posedge clk); while (!in_ready);
    pred = admit_beat(b);
    pending_results = {pending_results, (typed ? res : pred)};
  endtask

  // Drop valid and wait until every result is out and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_result(string why, budget_res_t w, budget_res_t a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d", why, cycle_cnt);
      $display("  expected st=%0d seen=%0d bytes=%0d client=%0d server=%0d sent=%0d sbytes=%0d",
               w.st, w.seen, w.bytes, w.client, w.server, w.sent, w.sbytes);
      $display("  actual   st=%0d seen=%0d bytes=%0d client=%0d server=%0d sent=%0d sbytes=%0d",
               a.st, a.seen, a.bytes, a.client, a.server, a.sent, a.sbytes);
    end
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      got_r = {status, seen_datagrams, seen_bytes, client_count, server_count,
               sent_datagrams, sent_bytes};
      if (pending_results.size() == 0) begin
        flag_result("result beat with nothing pending", '0, got_r);
      end else begin
        want_r = pending_results.pop_front();
        if (got_r !== want_r) flag_result("result mismatch", want_r, got_r);
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: random ready runs and stalls, plus one long hold-off
  initial begin
    int run;
    int stall;
    int sel;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else begin
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
        sel = $urandom_range(0, 7);
        if (sel < 4) stall = 0;
        else if (sel < 7) stall = $urandom_range(1, 4);
        else stall = $urandom_range(10, 40);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Stimulus: directed table, then random phases between limit updates
  initial begin
    stim_row_t                      rows[$];
    budget_res_t                    none;
    dba_pkg::item_t                 b;
    int                             random_done;
    int                             n;
    logic [dba_pkg::CNT_PORT_W-1:0] dg_lim;
    logic [dba_pkg::CNT_PORT_W-1:0] cl_lim;
    logic [dba_pkg::CNT_PORT_W-1:0] sv_lim;
    logic [dba_pkg::BYT_PORT_W-1:0] raw_lim;
    logic [dba_pkg::LEN_W-1:0]      pl_lim;

    none        = '0;
    random_done = 0;
    lim_payload = '1;
    lim_dgrams  = '1;
    lim_raw     = '1;
    lim_client  = '1;
    lim_server  = '1;
    seen_cnt    = '0;
    seen_byt    = '0;
    client_cnt  = '0;
    server_cnt  = '0;
    sent_cnt    = '0;
    sent_byt    = '0;

    // Fresh counters, length extremes, both commands and directions
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd0, dba_pkg::ST_OK,
                            1, 0, 1, 0, 0, 0)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'hFFFF, dba_pkg::ST_OK,
                            2, 65535, 1, 1, 0, 0)};
    rows = {rows, typed_row(dba_pkg::CMD_EMIT, 1'b1, 16'hFFFF, dba_pkg::ST_OK,
                            2, 65535, 1, 1, 1, 65535)};
    rows = {rows, typed_row(dba_pkg::CMD_EMIT, 1'b0, 16'd0, dba_pkg::ST_OK,
                            2, 65535, 1, 1, 2, 65535)};
    // Payload limit, including a zero limit; emission is not bound by it
    rows = {rows, cfg_row(dba_pkg::REG_MAX_PAYLOAD, 48'd100)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd101, dba_pkg::ST_PAYLOAD,
                            2, 65535, 1, 1, 2, 65535)};
    rows = {rows, beat_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'd100)};
    rows = {rows, beat_row(dba_pkg::CMD_EMIT, 1'b0, 16'hFFFF)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_PAYLOAD, 48'd0)};
    rows = {rows, beat_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd0)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd1, dba_pkg::ST_PAYLOAD,
                            4, 65635, 2, 2, 3, 131070)};
    // Datagram limit reached, then zero
    rows = {rows, cfg_row(dba_pkg::REG_MAX_PAYLOAD, ALL_ONES)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_DGRAMS, 48'd5)};
    rows = {rows, beat_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'd7)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd7, dba_pkg::ST_DATAGRAM,
                            5, 65642, 2, 3, 3, 131070)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_DGRAMS, 48'd0)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd0, dba_pkg::ST_DATAGRAM,
                            5, 65642, 2, 3, 3, 131070)};
    // Byte budget: one past, exactly to the limit, then zero
    rows = {rows, cfg_row(dba_pkg::REG_MAX_DGRAMS, ALL_ONES)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_RAW, 48'd65652)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd11, dba_pkg::ST_RAW,
                            5, 65642, 2, 3, 3, 131070)};
    rows = {rows, beat_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd10)};
    rows = {rows, beat_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'd0)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_RAW, 48'd0)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'd0, dba_pkg::ST_RAW,
                            7, 65652, 3, 4, 3, 131070)};
    // Per-direction limits
    rows = {rows, cfg_row(dba_pkg::REG_MAX_RAW, ALL_ONES)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_CLIENT, 48'd3)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd1, dba_pkg::ST_CLIENT,
                            7, 65652, 3, 4, 3, 131070)};
    rows = {rows, beat_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'd1)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_SERVER, 48'd5)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'd1, dba_pkg::ST_SERVER,
                            8, 65653, 3, 5, 3, 131070)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_CLIENT, ALL_ONES)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_SERVER, 48'd0)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'd0, dba_pkg::ST_SERVER,
                            8, 65653, 3, 5, 3, 131070)};
    rows = {rows, beat_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd2)};
    // Writes past the last register must not land anywhere
    rows = {rows, cfg_row(REG_SPARE_LO, 48'd0)};
    rows = {rows, cfg_row(REG_SPARE_HI, 48'd0)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b1, 16'd0, dba_pkg::ST_SERVER,
                            9, 65655, 4, 5, 3, 131070)};
    rows = {rows, beat_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd0)};
    // Check order: payload wins over datagram
    rows = {rows, cfg_row(dba_pkg::REG_MAX_SERVER, ALL_ONES)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_PAYLOAD, 48'd10)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_DGRAMS, 48'd0)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd11, dba_pkg::ST_PAYLOAD,
                            10, 65655, 5, 5, 3, 131070)};
    rows = {rows, typed_row(dba_pkg::CMD_OBSERVE, 1'b0, 16'd5, dba_pkg::ST_DATAGRAM,
                            10, 65655, 5, 5, 3, 131070)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_DGRAMS, ALL_ONES)};
    rows = {rows, cfg_row(dba_pkg::REG_MAX_PAYLOAD, ALL_ONES)};
    rows = {rows, beat_row(dba_pkg::CMD_EMIT, 1'b1, 16'd12345)};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the table; limit writes only with the block drained
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        if (i == 0 || !rows[i-1].is_cfg) settle();
        write_limit(rows[i].idx, rows[i].data);
      end else begin
        offer_beat(rows[i].beat, rows[i].typed, rows[i].res);
      end
    end

    // Random phases, each with a fresh set of limits
    while (random_done < RANDOM_BEATS) begin
      settle();
      pl_lim  = pick_payload_limit();
      dg_lim  = pick_count_limit(seen_cnt);
      raw_lim = pick_raw_limit();
      cl_lim  = pick_count_limit(client_cnt);
      sv_lim  = pick_count_limit(server_cnt);
      write_limit(dba_pkg::REG_MAX_PAYLOAD, {32'($urandom), pl_lim});
      write_limit(dba_pkg::REG_MAX_DGRAMS, {16'($urandom), dg_lim});
      write_limit(dba_pkg::REG_MAX_RAW, raw_lim);
      write_limit(dba_pkg::REG_MAX_CLIENT, {16'($urandom), cl_lim});
      write_limit(dba_pkg::REG_MAX_SERVER, {16'($urandom), sv_lim});
      if ($urandom_range(0, 3) == 0) begin
        write_limit(dba_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                    {16'($urandom), 32'($urandom)});
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 120);
      repeat (n) begin
        b = random_beat();
        offer_beat(b, 1'b0, none);
        random_done++;
      end
    end

    no_gaps = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
